// File: hdl/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared types, constants and the quarter-wave sine table of the waveform
// generator.
// ----------------------------------------------------------------------------
package wfg_pkg;

    // Sample, period and table geometry
    localparam int SAMPLE_WIDTH     = 16;
    localparam int PERIOD_WIDTH     = 16;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int DEPTH_BITS       = $clog2(SINE_TABLE_DEPTH);

    // Configuration port geometry
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // Field widths
    localparam int MODE_WIDTH  = 3;
    localparam int PHASE_WIDTH = 32;
    localparam int TRI_WIDTH   = 25;

    // Full scale and triangle constants
    localparam logic [SAMPLE_WIDTH-1:0] FULL_SCALE = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [TRI_WIDTH-1:0]    TRI_ONE    = {1'b1, {(TRI_WIDTH-1){1'b0}}};
    localparam int TRI_SHIFT = TRI_WIDTH - SAMPLE_WIDTH;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WAVE_MODE     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_STEP    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DUTY_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RISE_STEP     = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FALL_STEP     = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIC_ENABLE    = 3'd6;

    // Waveform modes (all other codes give sine)
    localparam logic [MODE_WIDTH-1:0] WAVE_SINE     = 3'd0;
    localparam logic [MODE_WIDTH-1:0] WAVE_IMPULSE  = 3'd1;
    localparam logic [MODE_WIDTH-1:0] WAVE_PULSE    = 3'd2;
    localparam logic [MODE_WIDTH-1:0] WAVE_TRIANGLE = 3'd3;

    // Register reset values
    localparam logic [MODE_WIDTH-1:0]   RST_WAVE_MODE     = WAVE_SINE;
    localparam logic [PHASE_WIDTH-1:0]  RST_PHASE_STEP    = 32'd42852281;
    localparam logic [PERIOD_WIDTH-1:0] RST_PERIOD_LENGTH = 16'd100;
    localparam logic [PERIOD_WIDTH-1:0] RST_DUTY_LENGTH   = 16'd50;
    localparam logic [TRI_WIDTH-1:0]    RST_RISE_STEP     = 25'd335544;
    localparam logic [TRI_WIDTH-1:0]    RST_FALL_STEP     = 25'd335544;

    // pi/2 in Q28
    localparam longint PI_HALF_Q28 = 64'sd421657428;

    // Configuration register set
    typedef struct packed {
        logic [MODE_WIDTH-1:0]   wave_mode;
        logic [PHASE_WIDTH-1:0]  phase_step;
        logic [PERIOD_WIDTH-1:0] period_length;
        logic [PERIOD_WIDTH-1:0] duty_length;
        logic [TRI_WIDTH-1:0]    rise_step;
        logic [TRI_WIDTH-1:0]    fall_step;
        logic                    mic_enable;
    } cfg_t;

    // Beat moving from the oscillator stage to the mixer
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] gen;
        logic signed [SAMPLE_WIDTH-1:0] mic;
    } stage_t;

    // Quarter-wave table, one entry past the quarter
    typedef logic [SAMPLE_WIDTH-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

    // Q28 Taylor series up to the x^15 term, evaluated at elaboration
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint    x;
        longint    x2;
        longint    term;
        longint    sum;
        longint    v;
        longint    full;
        int        k;
        full = longint'(FULL_SCALE);
        for (k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = (PI_HALF_Q28 * longint'(k) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
            x2   = (x * x + (64'sd1 <<< 27)) >>> 28;
            term = x;
            sum  = x;
            // terms x^3 .. x^15, divisors (2n)(2n+1), alternating sign
            term = ((term * x2) >>> 28) / 64'sd6;
            sum  = sum - term;
            term = ((term * x2) >>> 28) / 64'sd20;
            sum  = sum + term;
            term = ((term * x2) >>> 28) / 64'sd42;
            sum  = sum - term;
            term = ((term * x2) >>> 28) / 64'sd72;
            sum  = sum + term;
            term = ((term * x2) >>> 28) / 64'sd110;
            sum  = sum - term;
            term = ((term * x2) >>> 28) / 64'sd156;
            sum  = sum + term;
            term = ((term * x2) >>> 28) / 64'sd210;
            sum  = sum - term;
            if (sum < 0)
                sum = 0;
            v = (sum * full + (64'sd1 <<< 27)) >>> 28;
            if (v > full)
                v = full;
            tab[k] = v[SAMPLE_WIDTH-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: hdl/wfg_regs.sv
// ----------------------------------------------------------------------------
// wfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module wfg_regs
    import wfg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WAVE_MODE:     cfg_next.wave_mode     = cfg_wdata[MODE_WIDTH-1:0];
                REG_PHASE_STEP:    cfg_next.phase_step    = cfg_wdata[PHASE_WIDTH-1:0];
                REG_PERIOD_LENGTH: cfg_next.period_length = cfg_wdata[PERIOD_WIDTH-1:0];
                REG_DUTY_LENGTH:   cfg_next.duty_length   = cfg_wdata[PERIOD_WIDTH-1:0];
                REG_RISE_STEP:     cfg_next.rise_step     = cfg_wdata[TRI_WIDTH-1:0];
                REG_FALL_STEP:     cfg_next.fall_step     = cfg_wdata[TRI_WIDTH-1:0];
                REG_MIC_ENABLE:    cfg_next.mic_enable    = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_mode     <= RST_WAVE_MODE;
            cfg_reg.phase_step    <= RST_PHASE_STEP;
            cfg_reg.period_length <= RST_PERIOD_LENGTH;
            cfg_reg.duty_length   <= RST_DUTY_LENGTH;
            cfg_reg.rise_step     <= RST_RISE_STEP;
            cfg_reg.fall_step     <= RST_FALL_STEP;
            cfg_reg.mic_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/wfg_osc.sv
// ----------------------------------------------------------------------------
// wfg_osc
// Oscillator stage: phase, period and triangle state, waveform select and
// the input register of the pipeline.
// ----------------------------------------------------------------------------
module wfg_osc
    import wfg_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] mic_sample,
    output logic                           a_valid,
    output stage_t                         a_data,
    input  logic                           b_ready
);

    logic                    a_valid_reg;
    stage_t                  a_data_reg;
    stage_t                  a_data_next;
    logic [PHASE_WIDTH-1:0]  phase_acc_reg;
    logic [PHASE_WIDTH-1:0]  phase_acc_next;
    logic [PERIOD_WIDTH-1:0] period_pos_reg;
    logic [PERIOD_WIDTH-1:0] period_pos_next;
    logic [TRI_WIDTH-1:0]    tri_level_reg;
    logic [TRI_WIDTH-1:0]    tri_level_next;

    logic                    a_ready;
    logic                    accept;
    logic [PERIOD_WIDTH:0]   pos_inc;
    logic [TRI_WIDTH:0]      tri_rise;
    logic [SAMPLE_WIDTH:0]   tri_round;
    logic [SAMPLE_WIDTH-1:0] tri_out;
    logic [1:0]              quad;
    logic [DEPTH_BITS:0]     sine_idx;
    logic [SAMPLE_WIDTH-1:0] sine_mag;
    logic signed [SAMPLE_WIDTH-1:0] sine_val;
    logic signed [SAMPLE_WIDTH-1:0] gen;

    // Stage handshake
    assign a_ready  = !a_valid_reg || b_ready;
    assign accept   = in_valid && a_ready;
    assign in_stall = !a_ready;

    // Period position and phase advance
    assign pos_inc         = {1'b0, period_pos_reg} + 1'b1;
    assign period_pos_next = (pos_inc >= {1'b0, cfg.period_length}) ?
                             '0 : pos_inc[PERIOD_WIDTH-1:0];
    assign phase_acc_next  = phase_acc_reg + cfg.phase_step;

    // Triangle level for this beat
    assign tri_rise = {1'b0, tri_level_reg} + {1'b0, cfg.rise_step};
    always_comb
    begin
        if (period_pos_reg == '0)
            tri_level_next = '0;
        else if (period_pos_reg == cfg.duty_length)
            tri_level_next = TRI_ONE;
        else if (period_pos_reg < cfg.duty_length)
            tri_level_next = (tri_rise > {1'b0, TRI_ONE}) ? TRI_ONE : tri_rise[TRI_WIDTH-1:0];
        else
            tri_level_next = (tri_level_reg > cfg.fall_step) ?
                             tri_level_reg - cfg.fall_step : '0;
    end

    // Triangle output: round off the low bits, saturate at full scale
    assign tri_round = tri_level_next[TRI_WIDTH-1:TRI_SHIFT-1]
                       + {{SAMPLE_WIDTH{1'b0}}, 1'b1};
    assign tri_out   = tri_round[SAMPLE_WIDTH] ? FULL_SCALE
                       : ((tri_round[SAMPLE_WIDTH:1] > {1'b0, FULL_SCALE}) ? FULL_SCALE
                       : tri_round[SAMPLE_WIDTH-1:0] >> 1) ;

    // Quarter-wave sine lookup
    assign quad     = phase_acc_reg[PHASE_WIDTH-1 -: 2];
    assign sine_idx = quad[0] ?
                      (DEPTH_BITS+1)'(SINE_TABLE_DEPTH) -
                      {1'b0, phase_acc_reg[PHASE_WIDTH-3 -: DEPTH_BITS]} :
                      {1'b0, phase_acc_reg[PHASE_WIDTH-3 -: DEPTH_BITS]};
    assign sine_mag = sine_idx[DEPTH_BITS] ? SINE_TAB[SINE_TABLE_DEPTH]
                      : SINE_TAB[sine_idx[DEPTH_BITS-1:0]];
    assign sine_val = quad[1] ? -$signed(sine_mag) : $signed(sine_mag);

    // Waveform select
    always_comb
    begin
        case (cfg.wave_mode)
            WAVE_IMPULSE:  gen = (period_pos_reg == '0) ? $signed(FULL_SCALE) : '0;
            WAVE_PULSE:    gen = (period_pos_reg <= cfg.duty_length) ?
                                 $signed(FULL_SCALE) : '0;
            WAVE_TRIANGLE: gen = $signed(tri_out);
            default:       gen = sine_val;
        endcase
    end

    always_comb
    begin
        a_data_next.gen = gen;
        a_data_next.mic = mic_sample;
    end

    // State and stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            phase_acc_reg  <= '0;
            period_pos_reg <= '0;
            tri_level_reg  <= '0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (accept)
            begin
                phase_acc_reg  <= phase_acc_next;
                period_pos_reg <= period_pos_next;
                tri_level_reg  <= tri_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            a_data_reg <= a_data_next;
    end

    assign a_valid = a_valid_reg;
    assign a_data  = a_data_reg;

endmodule

// File: hdl/wfg_mix.sv
// ----------------------------------------------------------------------------
// wfg_mix
// Mixer stages: product register, then rounding, saturation and the
// output register.
// ----------------------------------------------------------------------------
module wfg_mix
    import wfg_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            mic_enable,
    input  logic                            a_valid,
    input  stage_t                          a_data,
    output logic                            b_ready,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  out_sample
);

    localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH;

    logic                           b_valid_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic signed [SAMPLE_WIDTH-1:0] gen_b_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_next;

    logic                           out_ready;
    logic                           b_load;
    logic                           c_load;
    logic signed [PROD_WIDTH:0]     prod_round;
    logic signed [PROD_WIDTH-SAMPLE_WIDTH+1:0] prod_shift;

    // Stage handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign b_ready   = !b_valid_reg || out_ready;
    assign b_load    = a_valid && b_ready;
    assign c_load    = b_valid_reg && out_ready;

    // Round to nearest, floor shift, saturate
    assign prod_round = {prod_reg[PROD_WIDTH-1], prod_reg}
                        + (PROD_WIDTH+1)'(1 << (SAMPLE_WIDTH - 2));
    assign prod_shift = prod_round[PROD_WIDTH:SAMPLE_WIDTH-1];

    always_comb
    begin
        if (!mic_enable)
            out_sample_next = gen_b_reg;
        else if (prod_shift > $signed({{(PROD_WIDTH-2*SAMPLE_WIDTH+2){1'b0}}, FULL_SCALE}))
            out_sample_next = $signed(FULL_SCALE);
        else if (prod_shift < -$signed({{(PROD_WIDTH-2*SAMPLE_WIDTH+2){1'b0}}, FULL_SCALE})
                              - 1)
            out_sample_next = $signed(~FULL_SCALE);
        else
            out_sample_next = prod_shift[SAMPLE_WIDTH-1:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= a_valid;
            if (out_ready)
                out_valid_reg <= b_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            prod_reg  <= a_data.gen * a_data.mic;
            gen_b_reg <= a_data.gen;
        end
        if (c_load)
            out_sample_reg <= out_sample_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

// File: hdl/multi_waveform_generator.sv
// ----------------------------------------------------------------------------
// multi_waveform_generator
// Sine, impulse, pulse and triangle generator with optional microphone
// modulation, one Q1.15 sample per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one mic_sample per sample
//   tick; each accepted beat yields exactly one out_sample beat on the
//   output channel (out_valid / out_stall), in order.
//   The oscillator register loads at the accepting edge, then the product
//   register and the output register that drives out_valid. Throughput is
//   one beat per cycle while out_stall is low; the 16x16 multiply has its
//   own stage. Under an output stall the pipeline keeps filling until all
//   three stages hold a beat, then in_stall rises; no beat is dropped.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
//   the pipeline is empty; writes to unused indexes are ignored.
//   Reset (rst_n low) clears the phase, period position and triangle level,
//   empties the pipeline and loads the default register values
//   (sine mode, microphone off).
// ----------------------------------------------------------------------------
module multi_waveform_generator
    import wfg_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]      cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] mic_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

    cfg_t   cfg;
    logic   a_valid;
    stage_t a_data;
    logic   b_ready;

    // Configuration registers
    wfg_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Oscillator stage
    wfg_osc u_osc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mic_sample (mic_sample),
        .a_valid    (a_valid),
        .a_data     (a_data),
        .b_ready    (b_ready)
    );

    // Mixer and output stages
    wfg_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .mic_enable (cfg.mic_enable),
        .a_valid    (a_valid),
        .a_data     (a_data),
        .b_ready    (b_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample)
    );

endmodule
